@@ rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned OCC_W   = 4;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
    logic        [CNT_W-1:0]   count;
  } cmd_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// channel   direction  handshake          payload
// command   in         start_i / busy_o   action_i, item_value_i, item_priority_i
// result    out        done_o             status_o, head_value_o, occupancy_o
//
// one transaction per cycle: every cell compares and shifts in the same cycle
// the result strobe follows in the cycle after the command is taken
// busy_o stays low, so a command may be given in every cycle
// rst_ni clears the entry count and the strobe; cell contents are not reset
// the receiver cannot stall: a result is shown for exactly one cycle
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      action_i,
  input  logic signed [VALUE_W-1:0] item_value_i,
  input  logic        [PRIO_W-1:0]  item_priority_i,
  output logic                      done_o,
  output logic        [1:0]         status_o,
  output logic signed [VALUE_W-1:0] head_value_o,
  output logic        [OCC_W-1:0]   occupancy_o
);

  logic        [CNT_W-1:0]   count_q, count_d;
  logic                      done_q;
  status_e                   status_q, status_d;
  logic signed [VALUE_W-1:0] head_q, head_d;
  logic                      accept;
  logic                      is_full, is_empty;
  cmd_t                      cmd;

  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic        [PRIO_W-1:0]  cell_prio  [DEPTH];
  logic                      cell_lt    [DEPTH];

  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = count_q == CNT_W'(DEPTH);
  assign is_empty = count_q == '0;

  always_comb begin
    cmd.ins   = accept && (action_i == ACT_INSERT) && !is_full;
    cmd.rem   = accept && (action_i == ACT_REMOVE) && !is_empty;
    cmd.value = item_value_i;
    cmd.prio  = item_priority_i;
    cmd.count = count_q;
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    head_d   = '0;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CNT_W'(1);
      head_d  = cell_value[0];
    end else if (action_i == ACT_INSERT) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv, rv;
    logic        [PRIO_W-1:0]  lp, rp;
    logic                      llt;

    if (i == 0) begin : g_first
      assign lv  = '0;
      assign lp  = '0;
      assign llt = 1'b0;
    end else begin : g_mid
      assign lv  = cell_value[i-1];
      assign lp  = cell_prio[i-1];
      assign llt = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = cell_value[i];
      assign rp = cell_prio[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
      assign rp = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .idx_i         (IDX_W'(i)),
      .cmd_i         (cmd),
      .left_value_i  (lv),
      .left_prio_i   (lp),
      .left_lt_i     (llt),
      .right_value_i (rv),
      .right_prio_i  (rp),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i]),
      .lt_o          (cell_lt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      head_q   <= head_d;
    end
  end

  assign occ_ext      = {{OCC_W{1'b0}}, count_q};
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign head_value_o = head_q;
  assign occupancy_o  = occ_ext[OCC_W-1:0];

  a_strobe_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted transaction");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without transaction");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_refused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_DONE)) |-> (head_value_o == '0))
    else $error("refused transaction returned a head value");

endmodule

@@ rtl/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk_i,
  input  logic        [IDX_W-1:0]   idx_i,
  input  cmd_t                      cmd_i,
  input  logic signed [VALUE_W-1:0] left_value_i,
  input  logic        [PRIO_W-1:0]  left_prio_i,
  input  logic                      left_lt_i,
  input  logic signed [VALUE_W-1:0] right_value_i,
  input  logic        [PRIO_W-1:0]  right_prio_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic        [PRIO_W-1:0]  prio_o,
  output logic                      lt_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic        [PRIO_W-1:0]  prio_q, prio_d;
  logic                      held;
  logic                      take;

  assign held = CNT_W'(idx_i) < cmd_i.count;
  // held entry of lower priority than the newcomer: it moves back a place
  assign lt_o = held && (prio_q < cmd_i.prio);
  // first free place also takes part when every held entry stays
  assign take = lt_o || (CNT_W'(idx_i) == cmd_i.count);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.ins && take) begin
      if (left_lt_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else begin
        value_d = cmd_i.value;
        prio_d  = cmd_i.prio;
      end
    end else if (cmd_i.rem) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] head;
    logic        [OCC_W-1:0]   occ;
  } queue_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic                      action_i = ACT_INSERT;
  logic signed [VALUE_W-1:0] item_value_i = '0;
  logic        [PRIO_W-1:0]  item_priority_i = '0;
  logic                      done_o;
  logic        [1:0]         status_o;
  logic signed [VALUE_W-1:0] head_value_o;
  logic        [OCC_W-1:0]   occupancy_o;

  // shadow copy of the sorted store
  logic signed [VALUE_W-1:0] held_value [DEPTH];
  logic        [PRIO_W-1:0]  held_prio [DEPTH];
  int                        held_count = 0;

  queue_result_t pending_results [$];
  int            sender_idle_pct = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            transaction_count = 0;
  int            insert_count = 0;
  int            remove_count = 0;
  int            full_refusal_count = 0;
  int            empty_refusal_count = 0;

  sorted_priority_queue u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .head_value_o   (head_value_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_priority_queue test failed");
      $finish;
    end
  end

  function automatic queue_result_t predict_queue(action_e act,
                                                  logic signed [VALUE_W-1:0] value,
                                                  logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int            pos;
    res.status = ST_DONE;
    res.head   = '0;
    if (act == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // lower priorities move back, equal ones stay ahead
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] < prio) begin
          held_value[pos] = held_value[pos-1];
          held_prio[pos]  = held_prio[pos-1];
          pos--;
        end
        held_value[pos] = value;
        held_prio[pos]  = prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.head = held_value[0];
      for (pos = 0; pos + 1 < held_count; pos++) begin
        held_value[pos] = held_value[pos+1];
        held_prio[pos]  = held_prio[pos+1];
      end
      held_count--;
    end
    res.occ = OCC_W'(held_count);
    return res;
  endfunction

  always @(posedge clk_i) begin : result_check
    queue_result_t exp_res;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d head %0d occupancy %0d",
                   $time, status_o, head_value_o, occupancy_o);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
            mismatch_count++;
          end
          if (head_value_o !== exp_res.head) begin
            $display("%0t: head_value expected %0d actual %0d",
                     $time, exp_res.head, head_value_o);
            mismatch_count++;
          end
          if (occupancy_o !== exp_res.occ) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, exp_res.occ, occupancy_o);
            mismatch_count++;
          end
          case (exp_res.status)
            ST_FULL:  full_refusal_count++;
            ST_EMPTY: empty_refusal_count++;
            default:  ;
          endcase
        end
      end
      // the command seen here is the one the block takes at this edge
      if (start_i && !busy_o) begin
        pending_results.push_back(predict_queue(action_e'(action_i), item_value_i,
                                                item_priority_i));
        transaction_count++;
        if (action_i == ACT_INSERT) insert_count++;
        else remove_count++;
      end
    end
  end

  task automatic send_command(action_e act, logic signed [VALUE_W-1:0] value,
                              logic [PRIO_W-1:0] prio);
    // each idle cycle is drawn on its own, so the idle share matches the percentage
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    action_i        <= act;
    item_value_i    <= value;
    item_priority_i <= prio;
    do @(posedge clk_i); while (busy_o);
  endtask

  // hold off until every result is back
  task automatic wait_idle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic test_directed();
    sender_idle_pct = 6;
    send_command(ACT_REMOVE, 32'sh7fffffff, 8'hff);
    send_command(ACT_INSERT, 32'sh80000000, 8'h00);
    send_command(ACT_INSERT, 32'sh7fffffff, 8'hff);
    send_command(ACT_INSERT, 32'sh00000000, 8'h80);
    // equal priority keeps arrival order
    send_command(ACT_INSERT, -32'sd1, 8'h80);
    send_command(ACT_INSERT, 32'sh55555555, 8'hff);
    send_command(ACT_INSERT, 32'shaaaaaaaa, 8'h00);
    send_command(ACT_INSERT, 32'sh00000001, 8'h01);
    send_command(ACT_INSERT, 32'sh00000002, 8'hfe);
    send_command(ACT_INSERT, 32'sh12345678, 8'hff);
    repeat (9) send_command(ACT_REMOVE, '0, '0);
    wait_idle();
  endtask

  task automatic test_random_traffic(int n_items, int idle_pct);
    int                        k;
    int                        insert_pct;
    action_e                   act;
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
    sender_idle_pct = idle_pct;
    insert_pct = 50;
    for (k = 0; k < n_items; k++) begin
      // bursts biased towards filling or draining, or evenly mixed
      if (k % 24 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 75;
        endcase
      end
      act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      case ($urandom_range(7))
        0:       value = 32'sh80000000;
        1:       value = 32'sh7fffffff;
        default: value = $urandom;
      endcase
      case ($urandom_range(3))
        1:       prio = PRIO_W'($urandom_range(3));
        2:       prio = 8'hfc | PRIO_W'($urandom_range(3));
        default: prio = PRIO_W'($urandom_range(255));
      endcase
      send_command(act, value, prio);
      if (k == n_items / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(180, 6);
    test_random_traffic(180, 54);
    test_random_traffic(180, 0);
    $display("covered %0d transactions: %0d inserts, %0d removes",
             transaction_count, insert_count, remove_count);
    $display("refusals seen: %0d on a full store, %0d on an empty store",
             full_refusal_count, empty_refusal_count);
    if (mismatch_count == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
dv/testbench.sv
